// File: rtl/wavpcm_pkg.sv
// ----------------------------------------------------------------------------
// WAV PCM stream parser package
// Shared types and constants: result word layout, kind and status codes,
// parse phases, queue sizing and RIFF chunk tags.
// ----------------------------------------------------------------------------
`default_nettype none

package wavpcm_pkg;

   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_FRAME  = 2'd1,
      KIND_ERROR  = 2'd2,
      KIND_END    = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_NOT_RIFF     = 3'd1,
      ST_NOT_WAVE     = 3'd2,
      ST_MISSING      = 3'd3,
      ST_NOT_PCM      = 3'd4,
      ST_NOT_16BIT    = 3'd5,
      ST_BAD_CHANNELS = 3'd6
   } status_type;

   typedef enum logic [3:0] {
      PH_RIFF  = 4'd0,
      PH_RSIZE = 4'd1,
      PH_WAVE  = 4'd2,
      PH_ID    = 4'd3,
      PH_SIZE  = 4'd4,
      PH_FMT   = 4'd5,
      PH_SKIP  = 4'd6,
      PH_PAD   = 4'd7,
      PH_DATA  = 4'd8,
      PH_DONE  = 4'd9
   } phase_type;

   localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
   localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
   localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
   localparam logic [31:0] TAG_DATA = 32'h6461_7461;

   localparam logic [31:0] FMT_MIN_LEN = 32'd16;
   localparam logic [15:0] FMT_PCM     = 16'd1;
   localparam logic [15:0] BITS_16     = 16'd16;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   typedef logic [QUEUE_PTR_W-1:0] qptr_type;
   typedef logic [QUEUE_PTR_W:0]   qcnt_type;

   typedef struct packed {
      kind_type           kind;
      status_type         status;
      logic [1:0]         channel_count;
      logic [31:0]        rate_hz;
      logic signed [15:0] left_sample;
      logic signed [15:0] right_sample;
      logic               last_result;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

endpackage

`default_nettype wire

// File: rtl/wav_pcm_stream_parser_core.sv
// A result word is written to the 4-entry queue when its byte is accepted, then to
// the output register. Throughput: one byte per cycle while req_stall is low; one
// result word leaves per cycle unless rsp_stall; req_stall rises at 3 or more entries.
// Reset: synchronous, clears the parse state, the queue and the output valid flag;
// no clearing pass, bytes are taken in the first cycle after reset.
// ----------------------------------------------------------------------------
// WAV PCM stream parser core
// Byte-wide RIFF/WAVE parser emitting header, error, stereo frame and end
// words; front end parses, a queue decouples it from the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module wav_pcm_stream_parser_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [7:0]         req_file_byte,
   input  wire logic               req_end_of_file,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_kind,
   output logic [2:0]              rsp_status,
   output logic [1:0]              rsp_channel_count,
   output logic [31:0]             rsp_rate_hz,
   output logic signed [15:0]      rsp_left_sample,
   output logic signed [15:0]      rsp_right_sample,
   output logic                    rsp_last_result
);

   logic                   accept;
   logic                   has_room;
   logic                   head_valid;
   logic                   pop;
   wavpcm_pkg::push_type   push;
   wavpcm_pkg::result_type head;
   wavpcm_pkg::result_type rsp_word;

   assign req_stall = !has_room;
   assign accept    = req_valid && !req_stall;

   wavpcm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .file_byte   (req_file_byte),
      .end_of_file (req_end_of_file),
      .push        (push)
   );

   wavpcm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid),
      .has_room   (has_room)
   );

   wavpcm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .rsp_stall  (rsp_stall),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_word   (rsp_word)
   );

   assign rsp_kind          = rsp_word.kind;
   assign rsp_status        = rsp_word.status;
   assign rsp_channel_count = rsp_word.channel_count;
   assign rsp_rate_hz       = rsp_word.rate_hz;
   assign rsp_left_sample   = rsp_word.left_sample;
   assign rsp_right_sample  = rsp_word.right_sample;
   assign rsp_last_result   = rsp_word.last_result;

   a_frame_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == wavpcm_pkg::KIND_FRAME |-> rsp_status == wavpcm_pkg::ST_OK)
      else $error("frame word carries nonzero status");

   a_header_channels: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == wavpcm_pkg::KIND_HEADER |->
      (rsp_channel_count == 2'd1 || rsp_channel_count == 2'd2))
      else $error("header word with bad channel count");

   a_error_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == wavpcm_pkg::KIND_ERROR |-> rsp_status != wavpcm_pkg::ST_OK)
      else $error("error word without error status");

   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result word valid right after reset");

endmodule

`default_nettype wire

// File: rtl/wavpcm_front.sv
// ----------------------------------------------------------------------------
// WAV PCM parser front end
// Consumes one file byte per accepted word, tracks the RIFF chunk walk and
// produces zero, one or two result words per byte for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module wavpcm_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire logic [7:0]           file_byte,
   input  wire logic                 end_of_file,
   output wavpcm_pkg::push_type      push
);

   wavpcm_pkg::phase_type phase_ff, phase_in;
   logic [4:0]  byte_counter_ff, byte_counter_in;
   logic [31:0] tag_shift_ff, tag_shift_in;
   logic [31:0] chunk_length_ff, chunk_length_in;
   logic [15:0] audio_format_ff, audio_format_in;
   logic [15:0] stored_channels_ff, stored_channels_in;
   logic [31:0] stored_rate_ff, stored_rate_in;
   logic [15:0] stored_bits_ff, stored_bits_in;
   logic        format_seen_ff, format_seen_in;
   logic [31:0] data_remaining_ff, data_remaining_in;
   logic [23:0] frame_bytes_ff, frame_bytes_in;

   logic [4:0]  cnt_inc;
   logic [31:0] len_next;
   logic [31:0] cl_dec;
   logic [31:0] dr_dec;
   logic [31:0] frame_size;
   logic        main_v, end_v, eof_v;
   wavpcm_pkg::result_type main_res, end_res, eof_res;
   logic [1:0]  res_count;

   function automatic wavpcm_pkg::result_type make_result(
      input wavpcm_pkg::kind_type   kind,
      input wavpcm_pkg::status_type status,
      input logic [1:0]             ch,
      input logic [31:0]            rate,
      input logic [15:0]            l,
      input logic [15:0]            r);
      wavpcm_pkg::result_type res;
      res.kind          = kind;
      res.status        = status;
      res.channel_count = ch;
      res.rate_hz       = rate;
      res.left_sample   = l;
      res.right_sample  = r;
      res.last_result   = 1'b0;
      return res;
   endfunction

   assign cnt_inc    = byte_counter_ff + 5'd1;
   assign len_next   = {file_byte, chunk_length_ff[31:8]};
   assign cl_dec     = chunk_length_ff - 32'd1;
   assign dr_dec     = data_remaining_ff - 32'd1;
   assign frame_size = (stored_channels_ff == 16'd2) ? 32'd4 : 32'd2;

   always_comb begin
      phase_in           = phase_ff;
      byte_counter_in    = byte_counter_ff;
      tag_shift_in       = tag_shift_ff;
      chunk_length_in    = chunk_length_ff;
      audio_format_in    = audio_format_ff;
      stored_channels_in = stored_channels_ff;
      stored_rate_in     = stored_rate_ff;
      stored_bits_in     = stored_bits_ff;
      format_seen_in     = format_seen_ff;
      data_remaining_in  = data_remaining_ff;
      frame_bytes_in     = frame_bytes_ff;
      main_v   = 1'b0;
      end_v    = 1'b0;
      eof_v    = 1'b0;
      main_res = '0;
      end_res  = make_result(wavpcm_pkg::KIND_END, wavpcm_pkg::ST_OK, 2'd0, 32'd0,
                             16'd0, 16'd0);
      eof_res  = '0;

      if (accept) begin
         case (phase_ff)
            wavpcm_pkg::PH_RIFF, wavpcm_pkg::PH_WAVE, wavpcm_pkg::PH_ID: begin
               tag_shift_in    = {tag_shift_ff[23:0], file_byte};
               byte_counter_in = cnt_inc;
               if (cnt_inc >= 5'd4) begin
                  byte_counter_in = 5'd0;
                  if (phase_ff == wavpcm_pkg::PH_RIFF) begin
                     if (tag_shift_in == wavpcm_pkg::TAG_RIFF) begin
                        phase_in = wavpcm_pkg::PH_RSIZE;
                     end else begin
                        main_v   = 1'b1;
                        main_res = make_result(wavpcm_pkg::KIND_ERROR,
                                               wavpcm_pkg::ST_NOT_RIFF, 2'd0, 32'd0,
                                               16'd0, 16'd0);
                        phase_in = wavpcm_pkg::PH_DONE;
                     end
                  end else if (phase_ff == wavpcm_pkg::PH_WAVE) begin
                     if (tag_shift_in == wavpcm_pkg::TAG_WAVE) begin
                        phase_in = wavpcm_pkg::PH_ID;
                     end else begin
                        main_v   = 1'b1;
                        main_res = make_result(wavpcm_pkg::KIND_ERROR,
                                               wavpcm_pkg::ST_NOT_WAVE, 2'd0, 32'd0,
                                               16'd0, 16'd0);
                        phase_in = wavpcm_pkg::PH_DONE;
                     end
                  end else begin
                     chunk_length_in = 32'd0;
                     phase_in        = wavpcm_pkg::PH_SIZE;
                  end
               end
            end
            wavpcm_pkg::PH_RSIZE: begin
               byte_counter_in = cnt_inc;
               if (cnt_inc >= 5'd4) begin
                  byte_counter_in = 5'd0;
                  phase_in        = wavpcm_pkg::PH_WAVE;
               end
            end
            wavpcm_pkg::PH_SIZE: begin
               chunk_length_in = len_next;
               byte_counter_in = cnt_inc;
               if (cnt_inc >= 5'd4) begin
                  byte_counter_in = 5'd0;
                  tag_shift_in    = {31'd0, len_next[0]};
                  if (tag_shift_ff == wavpcm_pkg::TAG_FMT) begin
                     if (len_next < wavpcm_pkg::FMT_MIN_LEN) begin
                        main_v   = 1'b1;
                        main_res = make_result(wavpcm_pkg::KIND_ERROR,
                                               wavpcm_pkg::ST_MISSING, 2'd0, 32'd0,
                                               16'd0, 16'd0);
                        phase_in = wavpcm_pkg::PH_DONE;
                     end else begin
                        audio_format_in    = 16'd0;
                        stored_channels_in = 16'd0;
                        stored_rate_in     = 32'd0;
                        stored_bits_in     = 16'd0;
                        format_seen_in     = 1'b1;
                        phase_in           = wavpcm_pkg::PH_FMT;
                     end
                  end else if (tag_shift_ff == wavpcm_pkg::TAG_DATA) begin
                     main_v   = 1'b1;
                     phase_in = wavpcm_pkg::PH_DONE;
                     if (!format_seen_ff) begin
                        main_res = make_result(wavpcm_pkg::KIND_ERROR,
                                               wavpcm_pkg::ST_MISSING, 2'd0, 32'd0,
                                               16'd0, 16'd0);
                     end else if (audio_format_ff != wavpcm_pkg::FMT_PCM) begin
                        main_res = make_result(wavpcm_pkg::KIND_ERROR,
                                               wavpcm_pkg::ST_NOT_PCM, 2'd0, 32'd0,
                                               16'd0, 16'd0);
                     end else if (stored_bits_ff != wavpcm_pkg::BITS_16) begin
                        main_res = make_result(wavpcm_pkg::KIND_ERROR,
                                               wavpcm_pkg::ST_NOT_16BIT, 2'd0, 32'd0,
                                               16'd0, 16'd0);
                     end else if (stored_channels_ff != 16'd1 &&
                                  stored_channels_ff != 16'd2) begin
                        main_res = make_result(wavpcm_pkg::KIND_ERROR,
                                               wavpcm_pkg::ST_BAD_CHANNELS, 2'd0, 32'd0,
                                               16'd0, 16'd0);
                     end else begin
                        main_res = make_result(wavpcm_pkg::KIND_HEADER,
                                               wavpcm_pkg::ST_OK,
                                               stored_channels_ff[1:0], stored_rate_ff,
                                               16'd0, 16'd0);
                        data_remaining_in = len_next;
                        frame_bytes_in    = 24'd0;
                        if (len_next < frame_size) begin
                           end_v = 1'b1;
                        end else begin
                           phase_in = wavpcm_pkg::PH_DATA;
                        end
                     end
                  end else begin
                     phase_in = (len_next == 32'd0) ? wavpcm_pkg::PH_ID
                                                    : wavpcm_pkg::PH_SKIP;
                  end
               end
            end
            wavpcm_pkg::PH_FMT: begin
               case (byte_counter_ff)
                  5'd0:    audio_format_in[7:0]     = file_byte;
                  5'd1:    audio_format_in[15:8]    = file_byte;
                  5'd2:    stored_channels_in[7:0]  = file_byte;
                  5'd3:    stored_channels_in[15:8] = file_byte;
                  5'd4:    stored_rate_in[7:0]      = file_byte;
                  5'd5:    stored_rate_in[15:8]     = file_byte;
                  5'd6:    stored_rate_in[23:16]    = file_byte;
                  5'd7:    stored_rate_in[31:24]    = file_byte;
                  5'd14:   stored_bits_in[7:0]      = file_byte;
                  5'd15:   stored_bits_in[15:8]     = file_byte;
                  default: ;
               endcase
               if (byte_counter_ff < 5'd16) begin
                  byte_counter_in = cnt_inc;
               end
               chunk_length_in = cl_dec;
               if (cl_dec == 32'd0) begin
                  phase_in = tag_shift_ff[0] ? wavpcm_pkg::PH_PAD : wavpcm_pkg::PH_ID;
               end
            end
            wavpcm_pkg::PH_SKIP: begin
               chunk_length_in = cl_dec;
               if (cl_dec == 32'd0) begin
                  phase_in = tag_shift_ff[0] ? wavpcm_pkg::PH_PAD : wavpcm_pkg::PH_ID;
               end
            end
            wavpcm_pkg::PH_PAD: begin
               phase_in = wavpcm_pkg::PH_ID;
            end
            wavpcm_pkg::PH_DATA: begin
               byte_counter_in   = cnt_inc;
               data_remaining_in = dr_dec;
               if ({27'd0, cnt_inc} >= frame_size) begin
                  main_v = 1'b1;
                  if (frame_size == 32'd4) begin
                     main_res = make_result(wavpcm_pkg::KIND_FRAME, wavpcm_pkg::ST_OK,
                                            2'd0, 32'd0,
                                            {frame_bytes_ff[15:8], frame_bytes_ff[23:16]},
                                            {file_byte, frame_bytes_ff[7:0]});
                  end else begin
                     main_res = make_result(wavpcm_pkg::KIND_FRAME, wavpcm_pkg::ST_OK,
                                            2'd0, 32'd0,
                                            {file_byte, frame_bytes_ff[7:0]},
                                            {file_byte, frame_bytes_ff[7:0]});
                  end
                  byte_counter_in = 5'd0;
                  frame_bytes_in  = 24'd0;
                  if (dr_dec < frame_size) begin
                     end_v    = 1'b1;
                     phase_in = wavpcm_pkg::PH_DONE;
                  end
               end else begin
                  frame_bytes_in = {frame_bytes_ff[15:0], file_byte};
               end
            end
            default: ;
         endcase

         if (end_of_file) begin
            if (phase_in == wavpcm_pkg::PH_DATA) begin
               eof_v   = 1'b1;
               eof_res = make_result(wavpcm_pkg::KIND_END, wavpcm_pkg::ST_OK, 2'd0,
                                     32'd0, 16'd0, 16'd0);
            end else if (phase_in != wavpcm_pkg::PH_DONE) begin
               eof_v   = 1'b1;
               eof_res = make_result(wavpcm_pkg::KIND_ERROR, wavpcm_pkg::ST_MISSING,
                                     2'd0, 32'd0, 16'd0, 16'd0);
            end
            phase_in           = wavpcm_pkg::PH_RIFF;
            byte_counter_in    = 5'd0;
            tag_shift_in       = 32'd0;
            chunk_length_in    = 32'd0;
            audio_format_in    = 16'd0;
            stored_channels_in = 16'd0;
            stored_rate_in     = 32'd0;
            stored_bits_in     = 16'd0;
            format_seen_in     = 1'b0;
            data_remaining_in  = 32'd0;
            frame_bytes_in     = 24'd0;
         end
      end

      res_count = 2'(main_v) + 2'(end_v) + 2'(eof_v);
      push.count  = res_count;
      push.first  = main_v ? main_res : (end_v ? end_res : eof_res);
      push.second = end_v ? end_res : eof_res;
      if (res_count == 2'd1) begin
         push.first.last_result = 1'b1;
      end
      if (res_count == 2'd2) begin
         push.second.last_result = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= wavpcm_pkg::PH_RIFF;
         byte_counter_ff    <= 5'd0;
         tag_shift_ff       <= 32'd0;
         chunk_length_ff    <= 32'd0;
         audio_format_ff    <= 16'd0;
         stored_channels_ff <= 16'd0;
         stored_rate_ff     <= 32'd0;
         stored_bits_ff     <= 16'd0;
         format_seen_ff     <= 1'b0;
         data_remaining_ff  <= 32'd0;
         frame_bytes_ff     <= 24'd0;
      end else begin
         phase_ff           <= phase_in;
         byte_counter_ff    <= byte_counter_in;
         tag_shift_ff       <= tag_shift_in;
         chunk_length_ff    <= chunk_length_in;
         audio_format_ff    <= audio_format_in;
         stored_channels_ff <= stored_channels_in;
         stored_rate_ff     <= stored_rate_in;
         stored_bits_ff     <= stored_bits_in;
         format_seen_ff     <= format_seen_in;
         data_remaining_ff  <= data_remaining_in;
         frame_bytes_ff     <= frame_bytes_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/wavpcm_queue.sv
// ----------------------------------------------------------------------------
// WAV PCM parser result queue
// Small FIFO between front and back end; takes up to two result words per
// cycle and hands out one.
// ----------------------------------------------------------------------------
`default_nettype none

module wavpcm_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire wavpcm_pkg::push_type   push,
   input  wire logic                   pop,
   output wavpcm_pkg::result_type      head,
   output logic                        head_valid,
   output logic                        has_room
);

   wavpcm_pkg::result_type entry_ff [wavpcm_pkg::QUEUE_DEPTH];
   wavpcm_pkg::qptr_type   wr_ptr_ff, wr_ptr_in;
   wavpcm_pkg::qptr_type   rd_ptr_ff, rd_ptr_in;
   wavpcm_pkg::qcnt_type   count_ff, count_in;
   wavpcm_pkg::qptr_type   wr_ptr_next;

   assign wr_ptr_next = wr_ptr_ff + wavpcm_pkg::qptr_type'(1);
   assign head        = entry_ff[rd_ptr_ff];
   assign head_valid  = (count_ff != '0);
   assign has_room    = (count_ff <= wavpcm_pkg::qcnt_type'(wavpcm_pkg::QUEUE_DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + wavpcm_pkg::qptr_type'(push.count);
      rd_ptr_in = pop ? rd_ptr_ff + wavpcm_pkg::qptr_type'(1) : rd_ptr_ff;
      count_in  = count_ff + wavpcm_pkg::qcnt_type'(push.count)
                  - wavpcm_pkg::qcnt_type'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/wavpcm_back.sv
// ----------------------------------------------------------------------------
// WAV PCM parser back end
// Output register for the result channel; pulls the next word from the
// queue whenever the register is empty or being taken.
// ----------------------------------------------------------------------------
`default_nettype none

module wavpcm_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire wavpcm_pkg::result_type   head,
   input  wire logic                     head_valid,
   input  wire logic                     rsp_stall,
   output logic                          pop,
   output logic                          rsp_valid,
   output wavpcm_pkg::result_type        rsp_word
);

   logic                   rsp_valid_ff, rsp_valid_in;
   wavpcm_pkg::result_type rsp_word_ff;

   assign pop          = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = pop || (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_word     = rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_word_ff <= head;
      end
   end

endmodule

`default_nettype wire
